### hw/rtl/bcta_pkg.sv
// ----------------------------------------------------------------------------
// BCD calendar time adjust - shared definitions
// Key codes, the time record type and the BCD digit fix helpers.
// ----------------------------------------------------------------------------
package bcta_pkg;

    // keypad scan codes
    localparam logic [7:0] KEY_YEAR_UP    = 8'h77;
    localparam logic [7:0] KEY_YEAR_DN    = 8'hb7;
    localparam logic [7:0] KEY_MONTH_UP   = 8'hd7;
    localparam logic [7:0] KEY_MONTH_DN   = 8'he7;
    localparam logic [7:0] KEY_DAY_UP     = 8'h7b;
    localparam logic [7:0] KEY_DAY_DN     = 8'hbb;
    localparam logic [7:0] KEY_HOUR_UP    = 8'hdb;
    localparam logic [7:0] KEY_HOUR_DN    = 8'heb;
    localparam logic [7:0] KEY_MIN_UP     = 8'h7d;
    localparam logic [7:0] KEY_MIN_DN     = 8'hbd;
    localparam logic [7:0] KEY_SEC_UP     = 8'hdd;
    localparam logic [7:0] KEY_SEC_DN     = 8'hed;
    localparam logic [7:0] KEY_WEEKDAY_UP = 8'h7e;
    localparam logic [7:0] KEY_WEEKDAY_DN = 8'hbe;

    localparam logic [7:0] CENTURY_RESET  = 8'h20;

    typedef struct packed {
        logic [7:0] sec;
        logic [7:0] min;
        logic [7:0] hour;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] weekday;
        logic [7:0] year;
    } t_time;

    // low digit reached ten or more with bits 3 and 1 set: clear it, carry up
    function automatic logic [7:0] fix_up(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if ((v & 8'h0a) == 8'h0a) begin
            r = (v & 8'hf0) + 8'h10;
        end
        return r;
    endfunction

    // low digit borrowed down to 0xF: make it 9
    function automatic logic [7:0] fix_down(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if ((v & 8'h0f) == 8'h0f) begin
            r = (v & 8'hf0) + 8'h09;
        end
        return r;
    endfunction

endpackage

### hw/rtl/bcta_adjust.sv
// ----------------------------------------------------------------------------
// BCD calendar time adjust - field step logic
// Applies one key code to the time record and the century byte.
// ----------------------------------------------------------------------------
module bcta_adjust
    import bcta_pkg::*;
(
    input  logic [7:0] i_key_code,
    input  t_time      i_time,
    input  logic [7:0] i_century,
    output t_time      o_time,
    output logic [7:0] o_century,
    output logic       o_write_back
);

    logic [7:0] c_norm;
    logic [7:0] year_inc;
    logic [7:0] month_inc;
    logic [7:0] month_dec;
    logic [7:0] hour_inc;
    logic [7:0] sec_up;
    logic [7:0] min_up;
    logic [7:0] wday_inc;
    logic [7:0] wday_dec;

    assign c_norm    = fix_down(fix_up(i_century));
    assign year_inc  = i_time.year + 8'h01;
    assign month_inc = i_time.month + 8'h01;
    assign month_dec = i_time.month - 8'h01;
    assign hour_inc  = i_time.hour + 8'h01;
    assign sec_up    = fix_up(i_time.sec + 8'h01);
    assign min_up    = fix_up(i_time.min + 8'h01);
    assign wday_inc  = i_time.weekday + 8'h01;
    assign wday_dec  = i_time.weekday - 8'h01;

    always_comb begin
        o_time       = i_time;
        o_century    = c_norm;
        o_write_back = 1'b1;
        case (i_key_code)
            KEY_YEAR_UP: begin
                if (year_inc == 8'h9a) begin
                    o_time.year = 8'h00;
                    o_century   = fix_up(c_norm + 8'h01);
                end else begin
                    o_time.year = fix_up(year_inc);
                end
            end
            KEY_YEAR_DN: begin
                if (i_time.year == 8'h00) begin
                    o_time.year = 8'h99;
                    o_century   = fix_down(c_norm - 8'h01);
                end else begin
                    o_time.year = fix_down(i_time.year - 8'h01);
                end
            end
            KEY_MONTH_UP: begin
                o_time.month = (month_inc == 8'h13) ? 8'h01 : fix_up(month_inc);
            end
            KEY_MONTH_DN: begin
                o_time.month = (month_dec == 8'h00) ? 8'h12 : fix_down(month_dec);
            end
            KEY_DAY_UP: begin
                o_time.day = (i_time.day == 8'h31) ? 8'h01 : fix_up(i_time.day + 8'h01);
            end
            KEY_DAY_DN: begin
                o_time.day = (i_time.day == 8'h01) ? 8'h31 : fix_down(i_time.day - 8'h01);
            end
            KEY_HOUR_UP: begin
                o_time.hour = (hour_inc == 8'h24) ? 8'h00 : fix_up(hour_inc);
            end
            KEY_HOUR_DN: begin
                o_time.hour = (i_time.hour == 8'h00) ? 8'h23
                                                     : fix_down(i_time.hour - 8'h01);
            end
            KEY_MIN_UP: begin
                o_time.min = (min_up == 8'h60) ? 8'h00 : min_up;
            end
            KEY_MIN_DN: begin
                o_time.min = (i_time.min == 8'h00) ? 8'h59 : fix_down(i_time.min - 8'h01);
            end
            KEY_SEC_UP: begin
                o_time.sec = (sec_up == 8'h60) ? 8'h00 : sec_up;
            end
            KEY_SEC_DN: begin
                o_time.sec = (i_time.sec == 8'h00) ? 8'h59 : fix_down(i_time.sec - 8'h01);
            end
            KEY_WEEKDAY_UP: begin
                o_time.weekday = (wday_inc == 8'h08) ? 8'h01 : wday_inc;
            end
            KEY_WEEKDAY_DN: begin
                o_time.weekday = (wday_dec == 8'h00) ? 8'h07 : wday_dec;
            end
            default: begin
                o_write_back = 1'b0;
            end
        endcase
    end

endmodule

### hw/rtl/bcd_calendar_time_adjust.sv
// A transaction accepted into the input register passes the key decode into the result register.
// Throughput: one transaction per cycle while the receiver does not stall; the key decode and BCD steps sit in one
// combinational pass between the input register and the result register.
// Reset (synchronous, active low) empties both stages and sets the century to BCD 20.
// ----------------------------------------------------------------------------
// BCD calendar time adjust
// Steps one real-time-clock field up or down per keypad code, keeps the century.
// ----------------------------------------------------------------------------
module bcd_calendar_time_adjust
    import bcta_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_key_code,
    input  logic [7:0] i_sec_bcd,
    input  logic [7:0] i_min_bcd,
    input  logic [7:0] i_hour_bcd,
    input  logic [7:0] i_day_bcd,
    input  logic [7:0] i_month_bcd,
    input  logic [7:0] i_weekday_bcd,
    input  logic [7:0] i_year_bcd,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_sec_out,
    output logic [7:0] o_min_out,
    output logic [7:0] o_hour_out,
    output logic [7:0] o_day_out,
    output logic [7:0] o_month_out,
    output logic [7:0] o_weekday_out,
    output logic [7:0] o_year_out,
    output logic [7:0] o_century_out,
    output logic       o_write_back
);

    logic       r_in_valid;
    logic [7:0] r_key;
    t_time      r_in_time;
    logic [7:0] r_century;
    logic       r_out_valid;
    t_time      r_out_time;
    logic       r_write_back;

    t_time      n_out_time;
    logic [7:0] n_century;
    logic       n_write_back;

    logic       out_free;
    logic       advance;
    logic       in_accept;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    bcta_adjust u_adjust (
        .i_key_code   (r_key),
        .i_time       (r_in_time),
        .i_century    (r_century),
        .o_time       (n_out_time),
        .o_century    (n_century),
        .o_write_back (n_write_back)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_century   <= CENTURY_RESET;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_century   <= n_century;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_key     <= i_key_code;
            r_in_time <= '{sec: i_sec_bcd, min: i_min_bcd, hour: i_hour_bcd,
                           day: i_day_bcd, month: i_month_bcd,
                           weekday: i_weekday_bcd, year: i_year_bcd};
        end
        if (advance) begin
            r_out_time   <= n_out_time;
            r_write_back <= n_write_back;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_sec_out     = r_out_time.sec;
    assign o_min_out     = r_out_time.min;
    assign o_hour_out    = r_out_time.hour;
    assign o_day_out     = r_out_time.day;
    assign o_month_out   = r_out_time.month;
    assign o_weekday_out = r_out_time.weekday;
    assign o_year_out    = r_out_time.year;
    assign o_century_out = r_century;
    assign o_write_back  = r_write_back;

`ifndef SYNTHESIS
    // stored century never holds a borrowed-out low digit
    a_century_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_century[3:0] != 4'hf)
        else $error("century low digit is 0xF");

    // century moves only with a transaction leaving the input stage
    a_century_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_century))
        else $error("century changed without a transaction");

    // input stall only while both the input stage and the result register hold a transaction
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with room in the pipeline");

    // a stage that advances fills the result register next cycle
    a_advance_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result lost after advance");
`endif

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BCD calendar time adjust testbench
// Drives keypad codes with RTC time bytes through a valid/stall input channel
// and checks every adjusted time record, century and write-back flag against
// an in-bench prediction. A short directed table covers the wrap points of
// every field and both century carries; random bursts, random output stalls
// and noise on keys and field values follow.
// ----------------------------------------------------------------------------
module tb_top;
    import bcta_pkg::*;

    localparam int RANDOM_ITEMS = 600;
    localparam int LIMIT_CYCLES = 200000;

    typedef struct packed {
        t_time      t;
        logic [7:0] century;
        logic       wb;
    } adj_rec_t;

    typedef struct packed {
        logic [7:0] key;
        t_time      stim;
        logic       typed;
        adj_rec_t   want;
    } dir_row_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_key_code = 8'hff;
    logic [7:0] i_sec_bcd = 8'h00;
    logic [7:0] i_min_bcd = 8'h00;
    logic [7:0] i_hour_bcd = 8'h00;
    logic [7:0] i_day_bcd = 8'h00;
    logic [7:0] i_month_bcd = 8'h00;
    logic [7:0] i_weekday_bcd = 8'h00;
    logic [7:0] i_year_bcd = 8'h00;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_sec_out;
    logic [7:0] o_min_out;
    logic [7:0] o_hour_out;
    logic [7:0] o_day_out;
    logic [7:0] o_month_out;
    logic [7:0] o_weekday_out;
    logic [7:0] o_year_out;
    logic [7:0] o_century_out;
    logic       o_write_back;

    adj_rec_t   adjusted_q[$];
    dir_row_t   dir_rows[$];
    logic [7:0] century_now = CENTURY_RESET;
    int         mismatch_cnt = 0;
    int         cycle_cnt = 0;
    int         burst_left = 0;
    int         stall_mode = 0;
    int         stall_left = 0;

    logic [7:0] adjust_keys[14] = '{KEY_YEAR_UP, KEY_YEAR_DN, KEY_MONTH_UP, KEY_MONTH_DN,
                                    KEY_DAY_UP, KEY_DAY_DN, KEY_HOUR_UP, KEY_HOUR_DN,
                                    KEY_MIN_UP, KEY_MIN_DN, KEY_SEC_UP, KEY_SEC_DN,
                                    KEY_WEEKDAY_UP, KEY_WEEKDAY_DN};

    bcd_calendar_time_adjust uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_key_code    (i_key_code),
        .i_sec_bcd     (i_sec_bcd),
        .i_min_bcd     (i_min_bcd),
        .i_hour_bcd    (i_hour_bcd),
        .i_day_bcd     (i_day_bcd),
        .i_month_bcd   (i_month_bcd),
        .i_weekday_bcd (i_weekday_bcd),
        .i_year_bcd    (i_year_bcd),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_sec_out     (o_sec_out),
        .o_min_out     (o_min_out),
        .o_hour_out    (o_hour_out),
        .o_day_out     (o_day_out),
        .o_month_out   (o_month_out),
        .o_weekday_out (o_weekday_out),
        .o_year_out    (o_year_out),
        .o_century_out (o_century_out),
        .o_write_back  (o_write_back)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // carry a low digit past nine with bits 3 and 1 set into the tens digit
    function automatic logic [7:0] carry_digit(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if ((v & 8'h0a) == 8'h0a) begin
            r = (v & 8'hf0) + 8'h10;
        end
        return r;
    endfunction

    // low digit borrowed below zero: make it nine
    function automatic logic [7:0] borrow_digit(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if ((v & 8'h0f) == 8'h0f) begin
            r = (v & 8'hf0) + 8'h09;
        end
        return r;
    endfunction

    function automatic logic [7:0] sixty_up(input logic [7:0] v);
        logic [7:0] r;
        r = carry_digit(v + 8'h01);
        if (r == 8'h60) begin
            r = 8'h00;
        end
        return r;
    endfunction

    function automatic logic [7:0] sixty_down(input logic [7:0] v);
        logic [7:0] r;
        r = (v == 8'h00) ? 8'h60 : v;
        return borrow_digit(r - 8'h01);
    endfunction

    // predict one transaction and advance the kept century
    function automatic adj_rec_t adjust_clock(input logic [7:0] key, input t_time t);
        adj_rec_t   r;
        logic [7:0] c;
        r.t  = t;
        r.wb = 1'b1;
        c = borrow_digit(carry_digit(century_now));
        case (key)
            KEY_YEAR_UP: begin
                r.t.year = t.year + 8'h01;
                if (r.t.year == 8'h9a) begin
                    r.t.year = 8'h00;
                    c = carry_digit(c + 8'h01);
                end
                r.t.year = carry_digit(r.t.year);
            end
            KEY_YEAR_DN: begin
                if (t.year == 8'h00) begin
                    r.t.year = 8'h99;
                    c = borrow_digit(c - 8'h01);
                end else begin
                    r.t.year = borrow_digit(t.year - 8'h01);
                end
            end
            KEY_MONTH_UP: begin
                r.t.month = t.month + 8'h01;
                if (r.t.month == 8'h13) begin
                    r.t.month = 8'h01;
                end
                r.t.month = carry_digit(r.t.month);
            end
            KEY_MONTH_DN: begin
                r.t.month = t.month - 8'h01;
                if (r.t.month == 8'h00) begin
                    r.t.month = 8'h12;
                end
                r.t.month = borrow_digit(r.t.month);
            end
            KEY_DAY_UP: begin
                r.t.day = (t.day == 8'h31) ? 8'h00 : t.day;
                r.t.day = carry_digit(r.t.day + 8'h01);
            end
            KEY_DAY_DN: begin
                r.t.day = (t.day == 8'h01) ? 8'h32 : t.day;
                r.t.day = borrow_digit(r.t.day - 8'h01);
            end
            KEY_HOUR_UP: begin
                r.t.hour = t.hour + 8'h01;
                if (r.t.hour == 8'h24) begin
                    r.t.hour = 8'h00;
                end
                r.t.hour = carry_digit(r.t.hour);
            end
            KEY_HOUR_DN: begin
                r.t.hour = (t.hour == 8'h00) ? 8'h24 : t.hour;
                r.t.hour = borrow_digit(r.t.hour - 8'h01);
            end
            KEY_MIN_UP:  r.t.min = sixty_up(t.min);
            KEY_MIN_DN:  r.t.min = sixty_down(t.min);
            KEY_SEC_UP:  r.t.sec = sixty_up(t.sec);
            KEY_SEC_DN:  r.t.sec = sixty_down(t.sec);
            KEY_WEEKDAY_UP: begin
                r.t.weekday = t.weekday + 8'h01;
                if (r.t.weekday == 8'h08) begin
                    r.t.weekday = 8'h01;
                end
            end
            KEY_WEEKDAY_DN: begin
                r.t.weekday = t.weekday - 8'h01;
                if (r.t.weekday == 8'h00) begin
                    r.t.weekday = 8'h07;
                end
            end
            default: r.wb = 1'b0;
        endcase
        century_now = c;
        r.century   = c;
        return r;
    endfunction

    // mostly in-range BCD, with range ends and raw bytes mixed in
    function automatic logic [7:0] pick_field(input int lo, input int hi);
        int         n;
        logic [7:0] r;
        case ($urandom_range(0, 7))
            0:       n = lo;
            1:       n = hi;
            default: n = $urandom_range(lo, hi);
        endcase
        r = 8'(((n / 10) << 4) | (n % 10));
        if ($urandom_range(0, 7) == 0) begin
            r = 8'($urandom_range(0, 255));
        end
        return r;
    endfunction

    function automatic t_time pick_time();
        t_time t;
        t.sec     = pick_field(0, 59);
        t.min     = pick_field(0, 59);
        t.hour    = pick_field(0, 23);
        t.day     = pick_field(1, 31);
        t.month   = pick_field(1, 12);
        t.weekday = pick_field(1, 7);
        t.year    = pick_field(0, 99);
        return t;
    endfunction

    function automatic logic [7:0] pick_key();
        logic [7:0] k;
        case ($urandom_range(0, 19))
            0, 1:    k = 8'hff;
            2:       k = 8'($urandom_range(0, 255));
            default: k = adjust_keys[$urandom_range(0, 13)];
        endcase
        return k;
    endfunction

    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        $display("[%0t] MISMATCH %s: got %h want %h", $time, what, got, want);
        mismatch_cnt++;
    endtask

    task automatic add_row(input logic [7:0] key, input t_time stim, input logic typed,
                           input adj_rec_t want);
        dir_row_t row;
        row.key   = key;
        row.stim  = stim;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    // one input transaction, preceded by a random gap, possibly none, when the current burst is used up
    task automatic send_item(input logic [7:0] key, input t_time t, input logic typed,
                             input adj_rec_t want);
        adj_rec_t guess;
        int       gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_key_code <= key;
        {i_sec_bcd, i_min_bcd, i_hour_bcd, i_day_bcd,
         i_month_bcd, i_weekday_bcd, i_year_bcd} <= t;
        do @(posedge i_clk); while (o_in_stall);
        guess = adjust_clock(key, t);
        adjusted_q.push_back(typed ? want : guess);
    endtask

    // receiver stall pattern: runs of cycles at 0, 25, 50 or 75 percent stall
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 80);
        end else begin
            stall_left--;
        end
        i_out_stall <= ($urandom_range(0, 3) < stall_mode);
    end

    always @(posedge i_clk) begin : result_check
        adj_rec_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (adjusted_q.size() == 0) begin
                flag_mismatch("unexpected result", o_sec_out, 8'h00);
            end else begin
                want = adjusted_q.pop_front();
                if (o_sec_out !== want.t.sec) begin
                    flag_mismatch("sec", o_sec_out, want.t.sec);
                end
                if (o_min_out !== want.t.min) begin
                    flag_mismatch("min", o_min_out, want.t.min);
                end
                if (o_hour_out !== want.t.hour) begin
                    flag_mismatch("hour", o_hour_out, want.t.hour);
                end
                if (o_day_out !== want.t.day) begin
                    flag_mismatch("day", o_day_out, want.t.day);
                end
                if (o_month_out !== want.t.month) begin
                    flag_mismatch("month", o_month_out, want.t.month);
                end
                if (o_weekday_out !== want.t.weekday) begin
                    flag_mismatch("weekday", o_weekday_out, want.t.weekday);
                end
                if (o_year_out !== want.t.year) begin
                    flag_mismatch("year", o_year_out, want.t.year);
                end
                if (o_century_out !== want.century) begin
                    flag_mismatch("century", o_century_out, want.century);
                end
                if (o_write_back !== want.wb) begin
                    flag_mismatch("write_back", {7'd0, o_write_back}, {7'd0, want.wb});
                end
            end
        end
    end

    initial begin
        // after reset: pass-through at both byte extremes
        add_row(8'hff, 56'h00_00_00_00_00_00_00, 1'b1, {56'h00_00_00_00_00_00_00, 8'h20, 1'b0});
        add_row(8'hff, 56'hff_ff_ff_ff_ff_ff_ff, 1'b1, {56'hff_ff_ff_ff_ff_ff_ff, 8'h20, 1'b0});
        // year wrap carries into and borrows from the century
        add_row(KEY_YEAR_UP, 56'h30_15_12_10_06_03_99, 1'b1,
                {56'h30_15_12_10_06_03_00, 8'h21, 1'b1});
        add_row(KEY_YEAR_DN, 56'h30_15_12_10_06_03_00, 1'b1,
                {56'h30_15_12_10_06_03_99, 8'h20, 1'b1});
        add_row(KEY_YEAR_DN, 56'h30_15_12_10_06_03_00, 1'b1,
                {56'h30_15_12_10_06_03_99, 8'h19, 1'b1});
        add_row(KEY_YEAR_UP, 56'h30_15_12_10_06_03_99, 1'b1,
                {56'h30_15_12_10_06_03_00, 8'h20, 1'b1});
        // range wrap of every other field, both directions
        add_row(KEY_MONTH_UP, 56'h30_15_12_10_12_03_25, 1'b1,
                {56'h30_15_12_10_01_03_25, 8'h20, 1'b1});
        add_row(KEY_MONTH_DN, 56'h30_15_12_10_01_03_25, 1'b1,
                {56'h30_15_12_10_12_03_25, 8'h20, 1'b1});
        add_row(KEY_DAY_UP, 56'h30_15_12_31_06_03_25, 1'b1,
                {56'h30_15_12_01_06_03_25, 8'h20, 1'b1});
        add_row(KEY_DAY_DN, 56'h30_15_12_01_06_03_25, 1'b1,
                {56'h30_15_12_31_06_03_25, 8'h20, 1'b1});
        add_row(KEY_HOUR_UP, 56'h30_15_23_10_06_03_25, 1'b1,
                {56'h30_15_00_10_06_03_25, 8'h20, 1'b1});
        add_row(KEY_HOUR_DN, 56'h30_15_00_10_06_03_25, 1'b1,
                {56'h30_15_23_10_06_03_25, 8'h20, 1'b1});
        add_row(KEY_MIN_UP, 56'h30_59_12_10_06_03_25, 1'b1,
                {56'h30_00_12_10_06_03_25, 8'h20, 1'b1});
        add_row(KEY_MIN_DN, 56'h30_00_12_10_06_03_25, 1'b1,
                {56'h30_59_12_10_06_03_25, 8'h20, 1'b1});
        add_row(KEY_SEC_UP, 56'h59_15_12_10_06_03_25, 1'b1,
                {56'h00_15_12_10_06_03_25, 8'h20, 1'b1});
        add_row(KEY_SEC_DN, 56'h00_15_12_10_06_03_25, 1'b1,
                {56'h59_15_12_10_06_03_25, 8'h20, 1'b1});
        add_row(KEY_WEEKDAY_UP, 56'h30_15_12_10_06_07_25, 1'b1,
                {56'h30_15_12_10_06_01_25, 8'h20, 1'b1});
        add_row(KEY_WEEKDAY_DN, 56'h30_15_12_10_06_01_25, 1'b1,
                {56'h30_15_12_10_06_07_25, 8'h20, 1'b1});
        // digit carry and borrow, non-BCD bytes, an unknown key
        add_row(KEY_YEAR_UP, 56'h30_15_12_10_06_03_09, 1'b0, '0);
        add_row(KEY_YEAR_DN, 56'h30_15_12_10_06_03_10, 1'b0, '0);
        add_row(KEY_MONTH_UP, 56'h30_15_12_10_09_03_25, 1'b0, '0);
        add_row(KEY_WEEKDAY_UP, 56'h30_15_12_10_06_ff_25, 1'b0, '0);
        add_row(KEY_MIN_UP, 56'h30_ff_12_10_06_03_25, 1'b0, '0);
        add_row(KEY_SEC_DN, 56'haf_15_12_10_06_03_25, 1'b0, '0);
        add_row(8'h00, 56'h5a_a5_ff_00_3c_c3_99, 1'b0, '0);

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].key, dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                // hold off until the pipeline has drained
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                while (adjusted_q.size() != 0) @(posedge i_clk);
            end
            send_item(pick_key(), pick_time(), 1'b0, '0);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (adjusted_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
